[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

[rtl/gsc_pkg.sv]
// Types and constants shared by the GGA sentence checker modules.
package gsc_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  computed_checksum;
    logic [7:0]  received_checksum;
    logic [9:0]  sentence_start;
    logic [6:0]  sentence_length;
    logic [7:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [21:0] file_number;
  } out_item_t;

  // Window summary handed from the byte parser to the clock unit.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] comp;
    logic [7:0] recv;
    logic [9:0] start;
    logic [6:0] len;
    logic [6:0] cap_h;
    logic [6:0] cap_m;
    logic [6:0] cap_s;
  } summary_t;

  typedef struct packed {
    logic [9:0] min_window;
    logic [9:0] max_window;
    logic [6:0] min_len;
    logic [6:0] max_len;
  } win_cfg_t;

  localparam logic       FUNC_BYTE = 1'b0;
  localparam logic       FUNC_TICK = 1'b1;

  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_NONE     = 2'd2;

  localparam logic [2:0] REG_TZ         = 3'd0;
  localparam logic [2:0] REG_MIN_WINDOW = 3'd1;
  localparam logic [2:0] REG_MAX_WINDOW = 3'd2;
  localparam logic [2:0] REG_MIN_LEN    = 3'd3;
  localparam logic [2:0] REG_MAX_LEN    = 3'd4;

  localparam logic [4:0] TZ_RESET         = 5'd3;
  localparam logic [9:0] MIN_WINDOW_RESET = 10'd160;
  localparam logic [9:0] MAX_WINDOW_RESET = 10'd630;
  localparam logic [6:0] MIN_LEN_RESET    = 7'd33;
  localparam logic [6:0] MAX_LEN_RESET    = 7'd99;

  localparam logic [9:0] WINDOW_LIMIT = 10'd1023;
  localparam logic [6:0] TIME_MARK    = 7'd127;
  localparam logic [6:0] BODY_MAX     = 7'd127;
  localparam logic [6:0] BODY_REJECT  = 7'd123;
  localparam logic [6:0] HDR_LEN      = 7'd7;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_LA     = 8'h61;

  // XOR of "GPGGA," (header minus the dollar)
  localparam logic [7:0] HDR_XOR = 8'h47 ^ 8'h50 ^ 8'h47 ^ 8'h47 ^ 8'h41 ^ 8'h2C;

  localparam int QUEUE_DEPTH = 2;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_DOLLAR;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h47;
      3'd5:    c = 8'h41;
      3'd6:    c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/gga_sentence_checker.sv]
// Top level of the GGA sentence checker: configuration registers and block wiring.
// One request (data byte or window tick) is taken every clock cycle. The byte
// parser updates all per-window state in the cycle the request is accepted; a
// closing request places a window summary in a two-entry queue unless the window
// is shorter than min_window, and the clock unit turns it into a result through
// stage A (clock update) and the output register (file number). in_ready drops
// only while that queue is full, which happens only when results are not being
// taken. Configuration is taken at once on any cycle with cfg_we high; indexes
// beyond the five registers are ignored.
module gga_sentence_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gsc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [9:0]         cfg_wdata
);

  logic [4:0]        tz_r;
  gsc_pkg::win_cfg_t win_cfg_r;
  logic              q_full, push, pop, q_valid;
  gsc_pkg::summary_t push_data, q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_r                 <= gsc_pkg::TZ_RESET;
      win_cfg_r.min_window <= gsc_pkg::MIN_WINDOW_RESET;
      win_cfg_r.max_window <= gsc_pkg::MAX_WINDOW_RESET;
      win_cfg_r.min_len    <= gsc_pkg::MIN_LEN_RESET;
      win_cfg_r.max_len    <= gsc_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gsc_pkg::REG_TZ:         tz_r                 <= cfg_wdata[4:0];
        gsc_pkg::REG_MIN_WINDOW: win_cfg_r.min_window <= cfg_wdata;
        gsc_pkg::REG_MAX_WINDOW: win_cfg_r.max_window <= cfg_wdata;
        gsc_pkg::REG_MIN_LEN:    win_cfg_r.min_len    <= cfg_wdata[6:0];
        gsc_pkg::REG_MAX_LEN:    win_cfg_r.max_len    <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  gsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (win_cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  gsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_full    (q_full)
  );

  gsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tz        (tz_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/gsc_front.sv]
// Byte parser: window counting, header match, XOR, hex digits and time capture.
module gsc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  gsc_pkg::win_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  gsc_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              push,
  output gsc_pkg::summary_t push_data
);

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_HEX    = 2'd2;
  localparam logic [1:0] PH_REJECT = 2'd3;

  logic [2:0] mp_r, mp_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [9:0] cnt_r, cnt_nxt;
  logic [9:0] start_r, start_nxt;
  logic [6:0] body_r, body_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] hex_r, hex_nxt;
  logic [1:0] hexn_r, hexn_nxt;
  logic       hexbad_r, hexbad_nxt;
  logic [6:0] caph_r, caph_nxt;
  logic [6:0] capm_r, capm_nxt;
  logic [6:0] caps_r, caps_nxt;

  logic       take, closing;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  function automatic logic [6:0] capture(input logic [6:0] field, input logic first,
                                         input logic [7:0] b);
    logic       dig;
    logic [6:0] d;
    logic [6:0] r;
    dig = (b inside {[8'h30:8'h39]});
    d   = 7'(b - gsc_pkg::CH_ZERO);
    r   = field;
    if (first) begin
      r = dig ? d : gsc_pkg::TIME_MARK;
    end else if (field != gsc_pkg::TIME_MARK && dig) begin
      // field is a single digit here, so the result stays below 100
      r = 7'(field * 7'd10) + d;
    end
    return r;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic [2:0] mpi;
    logic [7:0] len_w;
    logic [3:0] nib;
    logic       ok;

    mp_nxt     = mp_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    start_nxt  = start_r;
    body_nxt   = body_r;
    xor_nxt    = xor_r;
    hex_nxt    = hex_r;
    hexn_nxt   = hexn_r;
    hexbad_nxt = hexbad_r;
    caph_nxt   = caph_r;
    capm_nxt   = capm_r;
    caps_nxt   = caps_r;
    b          = in_data.data_byte;
    mpi        = (mp_r > 3'd6) ? 3'd0 : mp_r;
    len_w      = {1'b0, body_r} + 8'd5;
    nib        = 4'd0;
    ok         = 1'b0;
    push       = 1'b0;
    push_data  = '0;
    closing    = 1'b0;

    if (take && in_data.func == gsc_pkg::FUNC_BYTE) begin
      case (phase_r)
        PH_SEARCH: begin
          if (b == gsc_pkg::hdr_char(mpi)) begin
            if (mpi == 3'd6) begin
              xor_nxt   = gsc_pkg::HDR_XOR;
              start_nxt = cnt_r - 10'd6;
              body_nxt  = gsc_pkg::HDR_LEN;
              mp_nxt    = 3'd0;
              phase_nxt = PH_BODY;
            end else begin
              mp_nxt = mpi + 3'd1;
            end
          end else begin
            mp_nxt = (b == gsc_pkg::CH_DOLLAR) ? 3'd1 : 3'd0;
          end
        end
        PH_BODY: begin
          if (b == gsc_pkg::CH_STAR) begin
            if (body_r >= gsc_pkg::BODY_REJECT || len_w < {1'b0, cfg.min_len} ||
                len_w > {1'b0, cfg.max_len}) begin
              phase_nxt = PH_REJECT;
            end else begin
              phase_nxt = PH_HEX;
            end
          end else begin
            // hhmmss sits at sentence offsets 7 to 12
            case (body_r)
              7'd7:    caph_nxt = capture(caph_r, 1'b1, b);
              7'd8:    caph_nxt = capture(caph_r, 1'b0, b);
              7'd9:    capm_nxt = capture(capm_r, 1'b1, b);
              7'd10:   capm_nxt = capture(capm_r, 1'b0, b);
              7'd11:   caps_nxt = capture(caps_r, 1'b1, b);
              7'd12:   caps_nxt = capture(caps_r, 1'b0, b);
              default: ;
            endcase
            xor_nxt = xor_r ^ b;
            if (body_r < gsc_pkg::BODY_MAX) begin
              body_nxt = body_r + 7'd1;
            end
          end
        end
        PH_HEX: begin
          if (hexn_r < 2'd2) begin
            if (b inside {[8'h30:8'h39]}) begin
              nib = 4'(b - gsc_pkg::CH_ZERO);
            end else if (b inside {[8'h41:8'h46]}) begin
              nib = 4'(b - gsc_pkg::CH_UA + 8'd10);
            end else if (b inside {[8'h61:8'h66]}) begin
              nib = 4'(b - gsc_pkg::CH_LA + 8'd10);
            end else begin
              hexbad_nxt = 1'b1;
            end
            hex_nxt  = {hex_r[3:0], nib};
            hexn_nxt = hexn_r + 2'd1;
          end
        end
        default: ;
      endcase
      cnt_nxt = cnt_r + 10'd1;
      closing = (cnt_nxt > cfg.max_window) || (cnt_nxt == gsc_pkg::WINDOW_LIMIT);
    end else if (take) begin
      closing = 1'b1;
    end

    if (closing) begin
      push_data.status = gsc_pkg::ST_NONE;
      if (phase_nxt == PH_HEX) begin
        ok               = (hexn_nxt == 2'd2) && !hexbad_nxt;
        push_data.comp   = xor_nxt;
        push_data.start  = start_nxt;
        push_data.len    = body_nxt + 7'd5;
        push_data.recv   = ok ? hex_nxt : 8'd0;
        push_data.status = (ok && hex_nxt == xor_nxt) ? gsc_pkg::ST_GOOD
                                                      : gsc_pkg::ST_MISMATCH;
      end
      push_data.cap_h = caph_nxt;
      push_data.cap_m = capm_nxt;
      push_data.cap_s = caps_nxt;
      push            = (cnt_nxt >= cfg.min_window);

      mp_nxt     = 3'd0;
      phase_nxt  = PH_SEARCH;
      cnt_nxt    = 10'd0;
      start_nxt  = 10'd0;
      body_nxt   = 7'd0;
      xor_nxt    = 8'd0;
      hex_nxt    = 8'd0;
      hexn_nxt   = 2'd0;
      hexbad_nxt = 1'b0;
      caph_nxt   = gsc_pkg::TIME_MARK;
      capm_nxt   = gsc_pkg::TIME_MARK;
      caps_nxt   = gsc_pkg::TIME_MARK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_r     <= 3'd0;
      phase_r  <= PH_SEARCH;
      cnt_r    <= 10'd0;
      start_r  <= 10'd0;
      body_r   <= 7'd0;
      xor_r    <= 8'd0;
      hex_r    <= 8'd0;
      hexn_r   <= 2'd0;
      hexbad_r <= 1'b0;
      caph_r   <= gsc_pkg::TIME_MARK;
      capm_r   <= gsc_pkg::TIME_MARK;
      caps_r   <= gsc_pkg::TIME_MARK;
    end else begin
      mp_r     <= mp_nxt;
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      start_r  <= start_nxt;
      body_r   <= body_nxt;
      xor_r    <= xor_nxt;
      hex_r    <= hex_nxt;
      hexn_r   <= hexn_nxt;
      hexbad_r <= hexbad_nxt;
      caph_r   <= caph_nxt;
      capm_r   <= capm_nxt;
      caps_r   <= caps_nxt;
    end
  end

endmodule

[rtl/gsc_queue.sv]
// Two-entry queue of window summaries between parser and clock unit.
module gsc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gsc_pkg::summary_t push_data,
  input  logic              pop,
  output logic              q_valid,
  output gsc_pkg::summary_t q_data,
  output logic              q_full
);

  gsc_pkg::summary_t mem_r [gsc_pkg::QUEUE_DEPTH];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;

  assign q_valid = (count_r != 2'd0);
  assign q_full  = (count_r == 2'(gsc_pkg::QUEUE_DEPTH));
  assign q_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/gsc_back.sv]
// Clock unit: load and advance of the time of day, file number, result register.
module gsc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [4:0]         tz,
  input  logic               q_valid,
  input  gsc_pkg::summary_t  q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output gsc_pkg::out_item_t out_data
);

  localparam logic [21:0] HOUR_WEIGHT = 22'd10000;
  localparam logic [21:0] MIN_WEIGHT  = 22'd100;

  logic              a_v_r, a_v_nxt;
  gsc_pkg::summary_t a_r;
  logic [7:0]        hh_r, hh_nxt;
  logic [5:0]        mm_r, mm_nxt;
  logic [5:0]        ss_r, ss_nxt;
  logic              loaded_r, loaded_nxt;
  logic              out_valid_r, out_valid_nxt;
  gsc_pkg::out_item_t out_r;
  logic              a_move;

  function automatic logic [6:0] time_value(input logic [6:0] v);
    return (v > 7'd99) ? 7'd0 : v;
  endfunction

  function automatic logic [5:0] clamp59(input logic [6:0] v);
    return (v > 7'd59) ? 6'd59 : v[5:0];
  endfunction

  function automatic logic [5:0] floor12(input logic [5:0] s);
    logic [5:0] r;
    if (s >= 6'd48)      r = 6'd48;
    else if (s >= 6'd36) r = 6'd36;
    else if (s >= 6'd24) r = 6'd24;
    else if (s >= 6'd12) r = 6'd12;
    else                 r = 6'd0;
    return r;
  endfunction

  assign a_move    = a_v_r && (!out_valid_r || out_ready);
  assign pop       = q_valid && (!a_v_r || a_move);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic [7:0] h;
    logic [5:0] m;
    logic [5:0] s;
    h          = hh_r;
    m          = mm_r;
    s          = ss_r;
    loaded_nxt = loaded_r;
    if (q_data.status == gsc_pkg::ST_GOOD && !loaded_r) begin
      loaded_nxt = 1'b1;
      h          = 8'(time_value(q_data.cap_h)) + {3'd0, tz};
      m          = clamp59(time_value(q_data.cap_m));
      s          = clamp59(time_value(q_data.cap_s));
    end
    if (s < 6'd59) begin
      s = s + 6'd1;
    end else begin
      s = 6'd0;
      if (m < 6'd59) begin
        m = m + 6'd1;
      end else begin
        m = 6'd0;
        if (h != 8'd255) begin
          h = h + 8'd1;
        end
      end
    end
    hh_nxt = h;
    mm_nxt = m;
    ss_nxt = s;
    if (!pop) begin
      hh_nxt     = hh_r;
      mm_nxt     = mm_r;
      ss_nxt     = ss_r;
      loaded_nxt = loaded_r;
    end
    a_v_nxt       = pop ? 1'b1 : (a_move ? 1'b0 : a_v_r);
    out_valid_nxt = a_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_r <= q_data;
    end
    // clock registers still hold the values of the request in stage A here
    if (a_move) begin
      out_r.status            <= a_r.status;
      out_r.computed_checksum <= a_r.comp;
      out_r.received_checksum <= a_r.recv;
      out_r.sentence_start    <= a_r.start;
      out_r.sentence_length   <= a_r.len;
      out_r.hours             <= hh_r;
      out_r.minutes           <= mm_r;
      out_r.seconds           <= ss_r;
      out_r.file_number       <= 22'(hh_r) * HOUR_WEIGHT + 22'(mm_r) * MIN_WEIGHT +
                                 22'(floor12(ss_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
      hh_r        <= 8'd0;
      mm_r        <= 6'd0;
      ss_r        <= 6'd0;
      loaded_r    <= 1'b0;
    end else begin
      a_v_r       <= a_v_nxt;
      out_valid_r <= out_valid_nxt;
      hh_r        <= hh_nxt;
      mm_r        <= mm_nxt;
      ss_r        <= ss_nxt;
      loaded_r    <= loaded_nxt;
    end
  end

endmodule

[rtl/gsc_checker.sv]
// Port-level assertions for the GGA sentence checker, bound to the top level.
`include "assert_macros.svh"

module gsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input gsc_pkg::out_item_t out_data
);

  `CHK_IMPLY(a_status_code, clk, rst_n, out_valid, out_data.status == gsc_pkg::ST_GOOD || out_data.status == gsc_pkg::ST_MISMATCH || out_data.status == gsc_pkg::ST_NONE, "result status code out of range")

  `CHK_IMPLY(a_none_zero, clk, rst_n, out_valid && out_data.status == gsc_pkg::ST_NONE, out_data.computed_checksum == 8'd0 && out_data.received_checksum == 8'd0 && out_data.sentence_start == 10'd0 && out_data.sentence_length == 7'd0, "no-sentence result carries sentence fields")

  `CHK_IMPLY(a_clock_range, clk, rst_n, out_valid, out_data.minutes <= 6'd59 && out_data.seconds <= 6'd59, "clock minutes or seconds out of range")

  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed or dropped")

endmodule

bind gga_sentence_checker gsc_checker u_gsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
